FILE: hdl/ptpa_pkg.sv
package ptpa_pkg;

    localparam int SAMPLE_BITS    = 10;
    localparam int MAX_WINDOWS    = 255;
    localparam int COUNT_BITS     = $clog2(MAX_WINDOWS + 1);
    localparam int SUM_BITS       = SAMPLE_BITS + COUNT_BITS;
    localparam int MIN_BITS       = SAMPLE_BITS + 1;
    localparam int TICK_BITS      = 16;
    localparam int STEP_BITS      = $clog2(SUM_BITS);
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [TICK_BITS-1:0]  SHORT_RESET = TICK_BITS'(10);
    localparam logic [TICK_BITS-1:0]  LONG_RESET  = TICK_BITS'(100);
    localparam logic [TICK_BITS-1:0]  TICK_MAX    = '1;
    localparam logic [MIN_BITS-1:0]   MIN_RESET   = {1'b1, {SAMPLE_BITS{1'b0}}};
    localparam logic [COUNT_BITS-1:0] MAX_COUNT   = COUNT_BITS'(MAX_WINDOWS);
    localparam logic [STEP_BITS-1:0]  LAST_STEP   = STEP_BITS'(SUM_BITS - 1);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_ACK    = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SHORT_WINDOW = 2'd0,
        REG_LONG_WINDOW  = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic div_needed;
        logic div_last;
    } status_t;

endpackage

FILE: hdl/peak_to_peak_amplitude_averager.sv
// latency: result registered in the cycle after item accept, unless an average is published
// average publish runs a restoring divider (one quotient bit per cycle), then a publish state
// throughput: 1 item per cycle while no publish runs and out_stall is low; a publish holds input
// input stalls while the result register is full and stalled, or while the divider or publish runs
// reset: async active-low rst_n clears all but the divider operands; windows return to 10 and 100 ticks
module peak_to_peak_amplitude_averager (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ptpa_pkg::MODE_BITS-1:0]      mode,
    input  logic [ptpa_pkg::SAMPLE_BITS-1:0]    sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ptpa_pkg::SAMPLE_BITS-1:0]    level,
    output logic                                new_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ptpa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ptpa_pkg::TICK_BITS-1:0]      cfg_data
);

    ptpa_pkg::cmd_t    cmd;
    ptpa_pkg::status_t status;

    assign cfg_ready = 1'b1;

    ptpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ptpa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .sample    (sample),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .level     (level),
        .new_data  (new_data)
    );

endmodule

FILE: hdl/ptpa_ctrl.sv
module ptpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ptpa_pkg::status_t status,
    output ptpa_pkg::cmd_t    cmd
);

    ptpa_pkg::state_t state_reg;
    ptpa_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;
    logic             push;

    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptpa_pkg::ST_IDLE:
            begin
                if (in_valid && slot_free && status.div_needed)
                begin
                    state_next = ptpa_pkg::ST_DIVIDE;
                end
            end
            ptpa_pkg::ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ptpa_pkg::ST_PUBLISH;
                end
            end
            ptpa_pkg::ST_PUBLISH:
            begin
                if (slot_free)
                begin
                    state_next = ptpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        cmd.accept   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.publish  = 1'b0;
        push         = 1'b0;
        case (state_reg)
            ptpa_pkg::ST_IDLE:
            begin
                in_stall   = !slot_free;
                cmd.accept = in_valid && slot_free;
                push       = cmd.accept && !status.div_needed;
            end
            ptpa_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ptpa_pkg::ST_PUBLISH:
            begin
                cmd.publish = slot_free;
                push        = slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        out_valid_next = push || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptpa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hdl/ptpa_dp.sv
module ptpa_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ptpa_pkg::MODE_BITS-1:0]      mode,
    input  logic [ptpa_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic                                cfg_write,
    input  logic [ptpa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ptpa_pkg::TICK_BITS-1:0]      cfg_data,
    input  ptpa_pkg::cmd_t                      cmd,
    output ptpa_pkg::status_t                   status,
    output logic [ptpa_pkg::SAMPLE_BITS-1:0]    level,
    output logic                                new_data
);

    logic [ptpa_pkg::TICK_BITS-1:0]   short_ticks_reg, short_ticks_next;
    logic [ptpa_pkg::TICK_BITS-1:0]   long_ticks_reg, long_ticks_next;
    logic [ptpa_pkg::MIN_BITS-1:0]    min_reg, min_next;
    logic [ptpa_pkg::SAMPLE_BITS-1:0] max_reg, max_next;
    logic [ptpa_pkg::SUM_BITS-1:0]    sum_reg, sum_next;
    logic [ptpa_pkg::COUNT_BITS-1:0]  count_reg, count_next;
    logic [ptpa_pkg::TICK_BITS-1:0]   short_elapsed_reg, short_elapsed_next;
    logic [ptpa_pkg::TICK_BITS-1:0]   long_elapsed_reg, long_elapsed_next;
    logic [ptpa_pkg::SAMPLE_BITS-1:0] level_reg, level_next;
    logic                             flag_reg, flag_next;
    logic [ptpa_pkg::STEP_BITS-1:0]   step_reg, step_next;

    logic [ptpa_pkg::SUM_BITS-1:0]    quot_reg, quot_next;
    logic [ptpa_pkg::COUNT_BITS-1:0]  rem_reg, rem_next;
    logic [ptpa_pkg::COUNT_BITS-1:0]  divisor_reg;

    logic [ptpa_pkg::MIN_BITS-1:0]    sample_ext;
    logic [ptpa_pkg::MIN_BITS-1:0]    samp_min;
    logic [ptpa_pkg::SAMPLE_BITS-1:0] samp_max;
    logic [ptpa_pkg::MIN_BITS-1:0]    span;
    logic [ptpa_pkg::SAMPLE_BITS-1:0] p2p;
    logic                             short_exp;
    logic                             long_exp;
    logic [ptpa_pkg::COUNT_BITS:0]    trial;
    logic [ptpa_pkg::COUNT_BITS:0]    trial_diff;
    logic                             fits;

    // min / max tracking including the current sample
    assign sample_ext = {1'b0, sample};
    assign samp_min   = (sample_ext < min_reg) ? sample_ext : min_reg;
    assign samp_max   = (sample > max_reg) ? sample : max_reg;
    assign span       = {1'b0, samp_max} - samp_min;
    assign p2p        = ({1'b0, samp_max} >= samp_min) ? span[ptpa_pkg::SAMPLE_BITS-1:0] : '0;
    assign short_exp  = short_elapsed_reg >= short_ticks_reg;
    assign long_exp   = long_elapsed_reg >= long_ticks_reg;

    assign status.div_needed = (ptpa_pkg::mode_t'(mode) == ptpa_pkg::MODE_SAMPLE)
                               && short_exp && long_exp && !flag_reg && (count_reg != '0);
    assign status.div_last   = step_reg == ptpa_pkg::LAST_STEP;

    // restoring divider, one quotient bit per step
    assign trial      = {rem_reg, quot_reg[ptpa_pkg::SUM_BITS-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign fits       = trial >= {1'b0, divisor_reg};
    assign rem_next   = fits ? trial_diff[ptpa_pkg::COUNT_BITS-1:0]
                             : trial[ptpa_pkg::COUNT_BITS-1:0];
    assign quot_next  = {quot_reg[ptpa_pkg::SUM_BITS-2:0], fits};

    assign level    = level_reg;
    assign new_data = flag_reg;

    always_comb
    begin
        short_ticks_next   = short_ticks_reg;
        long_ticks_next    = long_ticks_reg;
        min_next           = min_reg;
        max_next           = max_reg;
        sum_next           = sum_reg;
        count_next         = count_reg;
        short_elapsed_next = short_elapsed_reg;
        long_elapsed_next  = long_elapsed_reg;
        level_next         = level_reg;
        flag_next          = flag_reg;
        step_next          = step_reg;

        if (cfg_write)
        begin
            case (ptpa_pkg::cfg_reg_t'(cfg_index))
                ptpa_pkg::REG_SHORT_WINDOW: short_ticks_next = cfg_data;
                ptpa_pkg::REG_LONG_WINDOW:  long_ticks_next  = cfg_data;
                default:                    short_ticks_next = short_ticks_reg;
            endcase
        end

        if (cmd.accept)
        begin
            step_next = '0;
            case (ptpa_pkg::mode_t'(mode))
                ptpa_pkg::MODE_SAMPLE:
                begin
                    if (!short_exp)
                    begin
                        min_next = samp_min;
                        max_next = samp_max;
                    end
                    else
                    begin
                        short_elapsed_next = '0;
                        max_next           = '0;
                        min_next           = ptpa_pkg::MIN_RESET;
                        if (long_exp)
                        begin
                            long_elapsed_next = '0;
                            sum_next          = '0;
                            count_next        = '0;
                        end
                        else if (count_reg < ptpa_pkg::MAX_COUNT)
                        begin
                            sum_next   = sum_reg + ptpa_pkg::SUM_BITS'(p2p);
                            count_next = count_reg + ptpa_pkg::COUNT_BITS'(1);
                        end
                    end
                end
                ptpa_pkg::MODE_TICK:
                begin
                    if (short_elapsed_reg != ptpa_pkg::TICK_MAX)
                    begin
                        short_elapsed_next = short_elapsed_reg + ptpa_pkg::TICK_BITS'(1);
                    end
                    if (long_elapsed_reg != ptpa_pkg::TICK_MAX)
                    begin
                        long_elapsed_next = long_elapsed_reg + ptpa_pkg::TICK_BITS'(1);
                    end
                end
                ptpa_pkg::MODE_ACK:
                begin
                    flag_next = 1'b0;
                end
                default:
                begin
                    flag_next = flag_reg;
                end
            endcase
        end

        if (cmd.div_step)
        begin
            step_next = step_reg + ptpa_pkg::STEP_BITS'(1);
        end

        if (cmd.publish)
        begin
            level_next = quot_reg[ptpa_pkg::SAMPLE_BITS-1:0];
            flag_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_ticks_reg   <= ptpa_pkg::SHORT_RESET;
            long_ticks_reg    <= ptpa_pkg::LONG_RESET;
            min_reg           <= ptpa_pkg::MIN_RESET;
            max_reg           <= '0;
            sum_reg           <= '0;
            count_reg         <= '0;
            short_elapsed_reg <= '0;
            long_elapsed_reg  <= '0;
            level_reg         <= '0;
            flag_reg          <= 1'b0;
            step_reg          <= '0;
        end
        else
        begin
            short_ticks_reg   <= short_ticks_next;
            long_ticks_reg    <= long_ticks_next;
            min_reg           <= min_next;
            max_reg           <= max_next;
            sum_reg           <= sum_next;
            count_reg         <= count_next;
            short_elapsed_reg <= short_elapsed_next;
            long_elapsed_reg  <= long_elapsed_next;
            level_reg         <= level_next;
            flag_reg          <= flag_next;
            step_reg          <= step_next;
        end
    end

    // divider operands, loaded with the sum and count before they clear
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            quot_reg    <= sum_reg;
            rem_reg     <= '0;
            divisor_reg <= count_reg;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

FILE: hdl/ptpa_checker.sv
module ptpa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [ptpa_pkg::MODE_BITS-1:0] mode,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [ptpa_pkg::SAMPLE_BITS-1:0] level,
    input logic                           new_data
);

    // non-sample items answer in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode != ptpa_pkg::MODE_SAMPLE) |=> out_valid)
        else $error("non-sample item did not produce a result");

    // flag only clears through an accepted acknowledge
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(new_data) |-> $past(in_valid && !in_stall && mode == ptpa_pkg::MODE_ACK))
        else $error("new_data cleared without acknowledge");

    // level only moves together with a fresh publish
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(level) |-> $rose(new_data))
        else $error("level changed without setting new_data");

    // no item is taken while a result is held up
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("item accepted while result stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(level) && $stable(new_data)))
        else $error("stalled result changed");

endmodule

bind peak_to_peak_amplitude_averager ptpa_checker u_ptpa_checker (.*);

FILE: test/tb_peak_to_peak_amplitude_averager.sv
`timescale 1ns / 1ps

module tb_peak_to_peak_amplitude_averager;

    localparam logic [ptpa_pkg::MODE_BITS-1:0]      MODE_UNUSED  = 2'd3;
    localparam logic [ptpa_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [ptpa_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 25;
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        logic [ptpa_pkg::SAMPLE_BITS-1:0] level;
        logic                             new_data;
    } level_result_t;

    logic                                clk;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [ptpa_pkg::MODE_BITS-1:0]      mode = ptpa_pkg::MODE_SAMPLE;
    logic [ptpa_pkg::SAMPLE_BITS-1:0]    sample = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [ptpa_pkg::SAMPLE_BITS-1:0]    level;
    logic                                new_data;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [ptpa_pkg::CFG_INDEX_BITS-1:0] cfg_index = ptpa_pkg::REG_SHORT_WINDOW;
    logic [ptpa_pkg::TICK_BITS-1:0]      cfg_data = '0;

    // amplitude tracking copy
    logic [ptpa_pkg::TICK_BITS-1:0]   short_len;
    logic [ptpa_pkg::TICK_BITS-1:0]   long_len;
    logic [ptpa_pkg::MIN_BITS-1:0]    pk_min;
    logic [ptpa_pkg::SAMPLE_BITS-1:0] pk_max;
    logic [ptpa_pkg::SUM_BITS-1:0]    pp_sum;
    logic [ptpa_pkg::COUNT_BITS-1:0]  pp_count;
    logic [ptpa_pkg::TICK_BITS-1:0]   short_ticks;
    logic [ptpa_pkg::TICK_BITS-1:0]   long_ticks;
    logic [ptpa_pkg::SAMPLE_BITS-1:0] level_reg;
    logic                             flag_reg;

    level_result_t level_expect_q[$];
    int bad_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    peak_to_peak_amplitude_averager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level     (level),
        .new_data  (new_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void reset_amplitude_state();
        short_len   = ptpa_pkg::SHORT_RESET;
        long_len    = ptpa_pkg::LONG_RESET;
        pk_min      = ptpa_pkg::MIN_RESET;
        pk_max      = '0;
        pp_sum      = '0;
        pp_count    = '0;
        short_ticks = '0;
        long_ticks  = '0;
        level_reg   = '0;
        flag_reg    = 1'b0;
    endfunction

    function automatic level_result_t amplitude_predict(
        logic [ptpa_pkg::MODE_BITS-1:0] m,
        logic [ptpa_pkg::SAMPLE_BITS-1:0] s);
        level_result_t r;
        logic [ptpa_pkg::SAMPLE_BITS-1:0] pp;
        if (m == ptpa_pkg::MODE_SAMPLE)
        begin
            if ({1'b0, s} < pk_min)
                pk_min = {1'b0, s};
            if (s > pk_max)
                pk_max = s;
            if (short_ticks >= short_len)
            begin
                short_ticks = '0;
                pp = ({1'b0, pk_max} >= pk_min)
                     ? ptpa_pkg::SAMPLE_BITS'({1'b0, pk_max} - pk_min) : '0;
                pk_max = '0;
                pk_min = ptpa_pkg::MIN_RESET;
                if (long_ticks >= long_len)
                begin
                    long_ticks = '0;
                    // publish only when the consumer has taken the last level
                    if (!flag_reg && pp_count != '0)
                    begin
                        level_reg = ptpa_pkg::SAMPLE_BITS'(pp_sum / pp_count);
                        flag_reg  = 1'b1;
                    end
                    pp_sum   = '0;
                    pp_count = '0;
                end
                else if (pp_count < ptpa_pkg::MAX_COUNT)
                begin
                    pp_sum   = pp_sum + pp;
                    pp_count = pp_count + 1'b1;
                end
            end
        end
        else if (m == ptpa_pkg::MODE_TICK)
        begin
            if (short_ticks != ptpa_pkg::TICK_MAX)
                short_ticks = short_ticks + 1'b1;
            if (long_ticks != ptpa_pkg::TICK_MAX)
                long_ticks = long_ticks + 1'b1;
        end
        else if (m == ptpa_pkg::MODE_ACK)
        begin
            flag_reg = 1'b0;
        end
        r.level    = level_reg;
        r.new_data = flag_reg;
        return r;
    endfunction

    function automatic logic [ptpa_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return ptpa_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [ptpa_pkg::TICK_BITS-1:0] pick_window(int hi);
        if ($urandom_range(5) == 0)
            return '0;
        return ptpa_pkg::TICK_BITS'($urandom_range(hi, 1));
    endfunction

    task automatic send_item(input logic [ptpa_pkg::MODE_BITS-1:0] m,
                             input logic [ptpa_pkg::SAMPLE_BITS-1:0] s);
        int gap;
        gap = 0;
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        sample   <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        level_expect_q.push_back(amplitude_predict(m, s));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (level_expect_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [ptpa_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [ptpa_pkg::TICK_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == ptpa_pkg::REG_SHORT_WINDOW)
            short_len = val;
        else if (idx == ptpa_pkg::REG_LONG_WINDOW)
            long_len = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        gap_pct   = 0;
        stall_pct = 0;
        // reset windows, empty state
        send_item(ptpa_pkg::MODE_SAMPLE, '1);
        send_item(ptpa_pkg::MODE_SAMPLE, '0);
        send_item(MODE_UNUSED, '1);
        send_item(ptpa_pkg::MODE_ACK, '0);
        send_item(ptpa_pkg::MODE_TICK, '0);
        wait_idle();
        cfg_write(ptpa_pkg::REG_SHORT_WINDOW, 16'd1);
        cfg_write(ptpa_pkg::REG_LONG_WINDOW, 16'd2);
        cfg_write(REG_SPARE_LO, '1);
        cfg_write(REG_SPARE_HI, '0);
        send_item(ptpa_pkg::MODE_SAMPLE, '0);
        send_item(ptpa_pkg::MODE_SAMPLE, '1);
        send_item(ptpa_pkg::MODE_TICK, '0);
        send_item(ptpa_pkg::MODE_SAMPLE, 10'd5);
        send_item(ptpa_pkg::MODE_SAMPLE, '1);
        send_item(ptpa_pkg::MODE_TICK, '1);
        send_item(ptpa_pkg::MODE_SAMPLE, 10'd500);
        send_item(ptpa_pkg::MODE_TICK, '0);
        send_item(ptpa_pkg::MODE_SAMPLE, 10'd200);
        send_item(ptpa_pkg::MODE_TICK, '0);
        send_item(ptpa_pkg::MODE_SAMPLE, 10'd900);
        send_item(ptpa_pkg::MODE_ACK, '1);
        wait_idle();
        // zero windows expire at every sample
        cfg_write(ptpa_pkg::REG_SHORT_WINDOW, '0);
        cfg_write(ptpa_pkg::REG_LONG_WINDOW, '0);
        send_item(ptpa_pkg::MODE_SAMPLE, '1);
        send_item(ptpa_pkg::MODE_SAMPLE, '0);
        send_item(ptpa_pkg::MODE_TICK, '0);
        send_item(ptpa_pkg::MODE_SAMPLE, 10'd77);
        wait_idle();
    endtask

    task automatic test_count_saturation();
        gap_pct   = 0;
        stall_pct = 0;
        wait_idle();
        cfg_write(ptpa_pkg::REG_SHORT_WINDOW, 16'd1);
        cfg_write(ptpa_pkg::REG_LONG_WINDOW, '1);
        send_item(ptpa_pkg::MODE_ACK, '0);
        repeat (260)
        begin
            send_item(ptpa_pkg::MODE_SAMPLE, pick_sample());
            send_item(ptpa_pkg::MODE_TICK, '0);
            send_item(ptpa_pkg::MODE_SAMPLE, pick_sample());
        end
        wait_idle();
        cfg_write(ptpa_pkg::REG_LONG_WINDOW, 16'd1);
        send_item(ptpa_pkg::MODE_TICK, '0);
        send_item(ptpa_pkg::MODE_SAMPLE, 10'd1);
        send_item(ptpa_pkg::MODE_ACK, '0);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
        int sent;
        for (int seg = 0; seg < 3; seg++)
        begin
            gap_pct   = 0;
            stall_pct = 0;
            wait_idle();
            cfg_write(ptpa_pkg::REG_SHORT_WINDOW, pick_window(4));
            cfg_write(ptpa_pkg::REG_LONG_WINDOW, pick_window(12));
            if ($urandom_range(1) == 0)
                cfg_write($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                          ptpa_pkg::TICK_BITS'($urandom));
            gap_pct   = send_pct;
            stall_pct = recv_pct;
            sent = 0;
            while (sent < n / 3)
            begin
                repeat ($urandom_range(5, 1))
                begin
                    send_item(ptpa_pkg::MODE_SAMPLE, pick_sample());
                    sent++;
                end
                repeat ($urandom_range(2))
                begin
                    send_item(ptpa_pkg::MODE_TICK, ptpa_pkg::SAMPLE_BITS'($urandom));
                    sent++;
                end
                if ($urandom_range(4) == 0)
                begin
                    send_item(ptpa_pkg::MODE_ACK, ptpa_pkg::SAMPLE_BITS'($urandom));
                    sent++;
                end
                if ($urandom_range(19) == 0)
                    send_item(MODE_UNUSED, ptpa_pkg::SAMPLE_BITS'($urandom));
                if ($urandom_range(29) == 0)
                begin
                    send_item(ptpa_pkg::MODE_BITS'($urandom_range(2)),
                              ptpa_pkg::SAMPLE_BITS'($urandom));
                    sent++;
                end
            end
        end
        wait_idle();
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        gap_pct   = 0;
        stall_pct = 0;
        wait_idle();
        cfg_write(ptpa_pkg::REG_SHORT_WINDOW, 16'd1);
        cfg_write(ptpa_pkg::REG_LONG_WINDOW, 16'd3);
        hold_req++;
        repeat (40)
        begin
            send_item(ptpa_pkg::MODE_SAMPLE, pick_sample());
            send_item(ptpa_pkg::MODE_TICK, '0);
        end
        wait_idle();
    endtask

    // receiver stall, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_served != hold_req)
        begin
            hold_served = hold_req;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        level_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (level_expect_q.size() == 0)
            begin
                bad_count++;
                if (bad_count <= 10)
                    $display("unexpected item: level %0d new_data %0b", level, new_data);
            end
            else
            begin
                want = level_expect_q.pop_front();
                if (level !== want.level || new_data !== want.new_data)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("mismatch: level exp %0d got %0d, new_data exp %0b got %0b",
                                 want.level, level, want.new_data, new_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        reset_amplitude_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_count_saturation();
        test_random_traffic(0, 0, 90);
        test_random_traffic(59, 0, 90);
        test_random_traffic(0, 59, 90);
        test_random_traffic(17, 17, 90);
        test_backpressure();
        wait_idle();
        if (bad_count == 0 && level_expect_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
